[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the URL field splitter.
// Needs clk_i and rst_ni in the scope of every use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock edge, off during reset.
`define UFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Same-cycle implication.
`define UFS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define UFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ufs_pkg.sv]
// Package of the URL field splitter: widths, character and state codes,
// and the port scanner state type. No dependencies.
`default_nettype none

package ufs_pkg;

  localparam int MaxLenDefault = 4096;

  localparam int FieldW   = 13;
  localparam int PortW    = 17;
  localparam int PortMagW = 16;
  localparam int OutDataW = 88;

  localparam logic [PortMagW-1:0] DefaultPortReset = 16'd80;
  localparam logic [PortMagW-1:0] PortSat          = 16'hFFFF;

  // parse phases
  localparam logic [1:0] PhProto = 2'd0;
  localparam logic [1:0] PhHost  = 2'd1;
  localparam logic [1:0] PhPort  = 2'd2;
  localparam logic [1:0] PhPath  = 2'd3;

  // port scan stages
  localparam logic [1:0] ScanSpace  = 2'd0;
  localparam logic [1:0] ScanDigits = 2'd1;
  localparam logic [1:0] ScanDone   = 2'd2;

  // result status
  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNoSep   = 2'd1;
  localparam logic [1:0] StNoHost  = 2'd2;
  localparam logic [1:0] StTooLong = 2'd3;

  // characters
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  typedef struct packed {
    logic [1:0]          stage;
    logic                neg;
    logic [PortMagW-1:0] accum;
  } port_scan_t;

endpackage

`default_nettype wire

[rtl/ufs_port_scan.sv]
// Port number scanner of the URL field splitter: skips blanks, takes one
// sign, then decimal digits with the magnitude saturated. Uses ufs_pkg.
`default_nettype none

module ufs_port_scan (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,   // byte belongs to the port text
  input  wire logic              clear_i,  // end of URL, start over
  input  wire logic [7:0]        byte_i,
  output ufs_pkg::port_scan_t    scan_o    // state including this byte
);

  ufs_pkg::port_scan_t scan_q, scan_d;

  logic        is_digit, is_blank, is_sign, in_digits;
  logic [19:0] acc_ext, prod;

  assign is_digit = (byte_i >= ufs_pkg::ChZero) && (byte_i <= ufs_pkg::ChNine);
  assign is_blank = (byte_i == ufs_pkg::ChSpace) ||
                    ((byte_i >= ufs_pkg::ChTab) && (byte_i <= ufs_pkg::ChCr));
  assign is_sign  = (byte_i == ufs_pkg::ChMinus) || (byte_i == ufs_pkg::ChPlus);

  // first non-blank, non-sign byte is itself a digit candidate
  assign in_digits = (scan_q.stage == ufs_pkg::ScanDigits) ||
                     ((scan_q.stage == ufs_pkg::ScanSpace) && !is_blank && !is_sign);

  // accum * 10 + digit
  assign acc_ext = {4'b0, scan_q.accum};
  assign prod    = (acc_ext << 3) + (acc_ext << 1) + {12'b0, byte_i - ufs_pkg::ChZero};

  always_comb begin
    scan_d = scan_q;
    if (step_i) begin
      if ((scan_q.stage == ufs_pkg::ScanSpace) && !is_blank) begin
        scan_d.stage = ufs_pkg::ScanDigits;
        if (byte_i == ufs_pkg::ChMinus) begin
          scan_d.neg = 1'b1;
        end
      end
      if (in_digits) begin
        if (is_digit) begin
          scan_d.accum = (prod > {4'b0, ufs_pkg::PortSat}) ? ufs_pkg::PortSat
                                                            : prod[15:0];
        end else begin
          scan_d.stage = ufs_pkg::ScanDone;
        end
      end
    end
  end

  assign scan_o = scan_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '{stage: ufs_pkg::ScanSpace, neg: 1'b0, accum: '0};
    end else if (clear_i) begin
      scan_q <= '{stage: ufs_pkg::ScanSpace, neg: 1'b0, accum: '0};
    end else begin
      scan_q <= scan_d;
    end
  end

endmodule

`default_nettype wire

[rtl/url_field_splitter_unit.sv]
// Output: the result is registered and appears in the cycle after the request carrying tlast is accepted.
// Throughput: one URL byte per cycle, back to back; a held result does not stop
// intake unless a second result would need the output register.
// Reset: rst_ni clears the parse state and sets default_port to 80; no sweep.
// Top level of the URL field splitter. Uses ufs_pkg, ufs_port_scan and
// assert_macros.svh.
`default_nettype none

module url_field_splitter_unit #(
  parameter int MAX_LEN = ufs_pkg::MaxLenDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // config: default_port
  input  wire logic                          cfg_valid_i,
  output      logic                          cfg_ready_o,
  input  wire logic [ufs_pkg::PortMagW-1:0]  cfg_data_i,
  // URL bytes
  input  wire logic                          s_axis_tvalid,
  output      logic                          s_axis_tready,
  input  wire logic [7:0]                    s_axis_tdata,   // [7:0] url_byte
  input  wire logic                          s_axis_tlast,   // last
  // results
  output      logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [1:0] status, [14:2] protocol_length, [27:15] host_start,
  // [40:28] host_length, [57:41] port, [58] port_given,
  // [71:59] path_start, [84:72] path_length, [87:85] zero
  output      logic [ufs_pkg::OutDataW-1:0]  m_axis_tdata
);

  localparam int PW = $clog2(MAX_LEN + 2);
  localparam logic [PW-1:0] MaxPos  = PW'(MAX_LEN);
  localparam logic [PW-1:0] MaxPos1 = PW'(MAX_LEN + 1);

  logic [ufs_pkg::PortMagW-1:0] default_port_q;

  logic [1:0]    sep_q, sep_d;
  logic [1:0]    phase_q, phase_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [PW-1:0] plen_q, plen_d;
  logic [PW-1:0] hbeg_q, hbeg_d;
  logic [PW-1:0] hlen_q, hlen_d;
  logic          colon_q, colon_d;
  logic [PW-1:0] pbeg_q, pbeg_d;

  logic          in_acc, in_last, in_range, scan_step;
  logic [7:0]    b;
  ufs_pkg::port_scan_t scan;

  logic [1:0]                   res_status;
  logic [ufs_pkg::PortW-1:0]    port_mag, port_val, res_port;
  logic                         port_is_m1;
  logic [PW-1:0]                res_pstart, res_plen;
  logic [ufs_pkg::OutDataW-1:0] res_data;

  logic                         out_valid_q;
  logic [ufs_pkg::OutDataW-1:0] out_data_q;

  assign cfg_ready_o   = 1'b1;
  // hold only a last byte while a result waits; other bytes keep flowing
  assign s_axis_tready = !out_valid_q || m_axis_tready || !s_axis_tlast;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_last       = in_acc && s_axis_tlast;
  assign b             = s_axis_tdata;
  assign in_range      = pos_q < MaxPos;

  always_comb begin
    sep_d   = sep_q;
    phase_d = phase_q;
    plen_d  = plen_q;
    hbeg_d  = hbeg_q;
    hlen_d  = hlen_q;
    colon_d = colon_q;
    pbeg_d  = pbeg_q;
    pos_d   = pos_q;
    if (in_acc) begin
      if (!in_range) begin
        pos_d = MaxPos1;  // count past the limit, parse nothing
      end else begin
        pos_d = pos_q + 1'b1;
        if (phase_q == ufs_pkg::PhProto) begin
          priority if ((sep_q == 2'd2) && (b == ufs_pkg::ChSlash)) begin
            plen_d  = pos_q - PW'(2);
            hbeg_d  = pos_q + 1'b1;
            sep_d   = 2'd0;
            phase_d = ufs_pkg::PhHost;
          end else if (b == ufs_pkg::ChColon) begin
            sep_d = 2'd1;
          end else if ((sep_q == 2'd1) && (b == ufs_pkg::ChSlash)) begin
            sep_d = 2'd2;
          end else begin
            sep_d = 2'd0;
          end
        end else if ((phase_q == ufs_pkg::PhHost) || (phase_q == ufs_pkg::PhPort)) begin
          if (b == ufs_pkg::ChSlash) begin
            pbeg_d  = pos_q;
            phase_d = ufs_pkg::PhPath;
          end else if (phase_q == ufs_pkg::PhHost) begin
            if (b == ufs_pkg::ChColon) begin
              colon_d = 1'b1;
              phase_d = ufs_pkg::PhPort;
            end else begin
              hlen_d = hlen_q + 1'b1;
            end
          end
        end
      end
    end
  end

  assign scan_step = in_acc && in_range && (phase_q == ufs_pkg::PhPort) &&
                     (b != ufs_pkg::ChSlash);

  ufs_port_scan u_port_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (scan_step),
    .clear_i (in_last),
    .byte_i  (b),
    .scan_o  (scan)
  );

  // result from the state including the last byte
  always_comb begin
    priority if (pos_d > MaxPos) begin
      res_status = ufs_pkg::StTooLong;
    end else if (phase_d == ufs_pkg::PhProto) begin
      res_status = ufs_pkg::StNoSep;
    end else if (pos_d == hbeg_d) begin
      res_status = ufs_pkg::StNoHost;
    end else begin
      res_status = ufs_pkg::StOk;
    end
  end

  assign port_mag   = {1'b0, scan.accum};
  assign port_val   = scan.neg ? (~port_mag + 1'b1) : port_mag;
  assign port_is_m1 = scan.neg && (scan.accum == ufs_pkg::PortMagW'(1));
  assign res_port   = (!colon_d || port_is_m1) ? {1'b0, default_port_q} : port_val;
  assign res_pstart = (phase_d == ufs_pkg::PhPath) ? pbeg_d : pos_d;
  assign res_plen   = (phase_d == ufs_pkg::PhPath) ? (pos_d - pbeg_d) : '0;

  always_comb begin
    res_data = '0;
    res_data[1:0] = res_status;
    if (res_status == ufs_pkg::StOk) begin
      res_data[14:2]  = ufs_pkg::FieldW'(plen_d);
      res_data[27:15] = ufs_pkg::FieldW'(hbeg_d);
      res_data[40:28] = ufs_pkg::FieldW'(hlen_d);
      res_data[57:41] = res_port;
      res_data[58]    = colon_d;
      res_data[71:59] = ufs_pkg::FieldW'(res_pstart);
      res_data[84:72] = ufs_pkg::FieldW'(res_plen);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_port_q <= ufs_pkg::DefaultPortReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      default_port_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q   <= 2'd0;
      phase_q <= ufs_pkg::PhProto;
      pos_q   <= '0;
      plen_q  <= '0;
      hbeg_q  <= '0;
      hlen_q  <= '0;
      colon_q <= 1'b0;
      pbeg_q  <= '0;
    end else if (in_last) begin
      // drop the parse state, ready for the next URL
      sep_q   <= 2'd0;
      phase_q <= ufs_pkg::PhProto;
      pos_q   <= '0;
      plen_q  <= '0;
      hbeg_q  <= '0;
      hlen_q  <= '0;
      colon_q <= 1'b0;
      pbeg_q  <= '0;
    end else begin
      sep_q   <= sep_d;
      phase_q <= phase_d;
      pos_q   <= pos_d;
      plen_q  <= plen_d;
      hbeg_q  <= hbeg_d;
      hlen_q  <= hlen_d;
      colon_q <= colon_d;
      pbeg_q  <= pbeg_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_last) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_last) begin
      out_data_q <= res_data;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`include "assert_macros.svh"

  `UFS_ASSERT(a_pos_bound, pos_q <= MaxPos1, "position beyond saturation value")
  `UFS_ASSERT_IMPL(a_rise_after_last, $rose(out_valid_q), $past(in_last),
                   "result raised without a last byte")
  `UFS_ASSERT_IMPL(a_err_fields_zero,
                   out_valid_q && (out_data_q[1:0] != ufs_pkg::StOk),
                   out_data_q[87:2] == '0, "error result carries field data")
  `UFS_ASSERT_NEXT(a_clear_after_last, in_last,
                   (pos_q == '0) && (phase_q == ufs_pkg::PhProto) && out_valid_q,
                   "parse state not cleared after last byte")

endmodule

`default_nettype wire
